// ===== sv/drs_pkg.sv =====
package drs_pkg;

  localparam int MAX_BATCH = 32;
  localparam int IDX_W = $clog2(MAX_BATCH);
  localparam int CNT_W = $clog2(MAX_BATCH + 1);
  localparam int CYL_W = 16;
  localparam int TAG_W = 8;

  localparam logic [1:0] MODE_SSTF  = 2'd1;
  localparam logic [1:0] MODE_CLOOK = 2'd2;

  localparam logic ADDR_MODE  = 1'b0;
  localparam logic ADDR_BATCH = 1'b1;

  typedef enum logic [2:0] {
    ST_COLLECT,
    ST_START,
    ST_SCAN,
    ST_PICK,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic store;
    logic start_batch;
    logic scan_clear;
    logic scan_step;
    logic pick;
    logic emit_done;
  } ctrl_t;

  typedef struct packed {
    logic                     count_zero;
    logic                     limit_hit;
    logic                     scan_last;
    logic                     emit_last;
    logic                     out_busy;
  } stat_t;

endpackage

// ===== sv/disk_request_scheduler_unit.sv =====
// Each result comes from a registered scan of the pending store, one entry per cycle,
// followed by a pick and an emit; the emit waits while the output register is held.
// Requests are taken one per cycle while a batch is collected; in_tready is low
// from batch close until the last result is loaded into the output register.
// Reset (rst_n, synchronous): mode 0, batch size 32, head 0, nothing pending.
module disk_request_scheduler_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,  // cylinder[15:0], request_tag[7:0] (lsb up)
  input  logic        in_tuser,  // has_request
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // served_tag[7:0], served_cylinder[15:0]
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [1:0] mode_r;
  logic [5:0] batch_r;
  drs_pkg::ctrl_t ctrl;
  drs_pkg::stat_t stat;
  logic [drs_pkg::CYL_W-1:0] ocyl;
  logic [drs_pkg::TAG_W-1:0] otag;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      batch_r <= 6'd32;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == drs_pkg::ADDR_MODE) mode_r <= cfg_pwdata[1:0];
      else batch_r <= cfg_pwdata[5:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == drs_pkg::ADDR_BATCH) ? {26'd0, batch_r} : {30'd0, mode_r};

  drs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_end(in_tlast), .stat(stat), .ctrl(ctrl)
  );

  drs_dp u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .stat(stat),
    .in_has(in_tuser), .in_end(in_tlast), .in_cyl(in_tdata[15:0]), .in_tag(in_tdata[23:16]),
    .mode(mode_r), .batch(batch_r),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_cyl(ocyl), .out_tag(otag), .out_last(out_tlast)
  );

  assign out_tdata = {ocyl, otag};

endmodule

// ===== sv/drs_ctrl.sv =====
module drs_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic            in_end,
  input  drs_pkg::stat_t  stat,
  output drs_pkg::ctrl_t  ctrl
);

  drs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= drs_pkg::ST_COLLECT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      drs_pkg::ST_COLLECT: begin
        if (in_tvalid && (in_end || stat.limit_hit)) begin
          state_nxt = drs_pkg::ST_START;
        end
      end
      drs_pkg::ST_START: begin
        state_nxt = stat.count_zero ? drs_pkg::ST_COLLECT : drs_pkg::ST_SCAN;
      end
      drs_pkg::ST_SCAN: begin
        if (stat.scan_last) state_nxt = drs_pkg::ST_PICK;
      end
      drs_pkg::ST_PICK: begin
        state_nxt = drs_pkg::ST_EMIT;
      end
      drs_pkg::ST_EMIT: begin
        if (!stat.out_busy) begin
          state_nxt = stat.emit_last ? drs_pkg::ST_COLLECT : drs_pkg::ST_SCAN;
        end
      end
      default: state_nxt = drs_pkg::ST_COLLECT;
    endcase
  end

  always_comb begin
    ctrl = '0;
    in_tready = 1'b0;
    unique case (state_r)
      drs_pkg::ST_COLLECT: begin
        in_tready = 1'b1;
        ctrl.store = in_tvalid;
      end
      drs_pkg::ST_START: begin
        ctrl.start_batch = 1'b1;
        ctrl.scan_clear = 1'b1;
      end
      drs_pkg::ST_SCAN: ctrl.scan_step = 1'b1;
      drs_pkg::ST_PICK: ctrl.pick = 1'b1;
      drs_pkg::ST_EMIT: begin
        if (!stat.out_busy) begin
          ctrl.emit_done = 1'b1;
          ctrl.scan_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== sv/drs_dp.sv =====
module drs_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  drs_pkg::ctrl_t               ctrl,
  output drs_pkg::stat_t               stat,
  input  logic                         in_has,
  input  logic                         in_end,
  input  logic [drs_pkg::CYL_W-1:0]    in_cyl,
  input  logic [drs_pkg::TAG_W-1:0]    in_tag,
  input  logic [1:0]                   mode,
  input  logic [5:0]                   batch,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [drs_pkg::CYL_W-1:0]    out_cyl,
  output logic [drs_pkg::TAG_W-1:0]    out_tag,
  output logic                         out_last
);

  localparam int IW = drs_pkg::IDX_W;
  localparam int CW = drs_pkg::CNT_W;

  logic [drs_pkg::CYL_W-1:0] cyl_mem [drs_pkg::MAX_BATCH];
  logic [drs_pkg::TAG_W-1:0] tag_mem [drs_pkg::MAX_BATCH];
  logic [drs_pkg::MAX_BATCH-1:0] served_r, served_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] n_r;
  logic [drs_pkg::CYL_W-1:0] head_r;
  logic [1:0] mode_r;
  logic [CW-1:0] scan_r, slot_r;
  logic found_r;
  logic [IW-1:0] best_r;
  logic [drs_pkg::CYL_W:0] bkey_r;
  logic hi_r;
  logic [IW-1:0] sel_r;
  logic out_v_r;
  logic [drs_pkg::CYL_W-1:0] ocyl_r;
  logic [drs_pkg::TAG_W-1:0] otag_r;
  logic olast_r;
  logic rd_v_r;
  logic [IW-1:0] rd_idx_r;
  logic [drs_pkg::CYL_W-1:0] rd_cyl_r;

  logic [CW-1:0] limit;
  logic [CW-1:0] count_add;
  logic close;
  logic [IW-1:0] si;
  logic [drs_pkg::CYL_W-1:0] d;
  logic [drs_pkg::CYL_W:0] key;
  logic better;
  logic [IW-1:0] pick;

  always_comb begin
    if (batch == 6'd0) limit = CW'(1);
    else if ({1'b0, batch} > 7'(drs_pkg::MAX_BATCH)) limit = CW'(drs_pkg::MAX_BATCH);
    else limit = CW'(batch);
  end

  assign si = scan_r[IW-1:0];
  assign d = (rd_cyl_r >= head_r) ? rd_cyl_r - head_r : head_r - rd_cyl_r;
  // C-LOOK key: cylinders below head rank after those at or above it
  assign key = (mode_r == drs_pkg::MODE_SSTF) ? {1'b0, d} : {rd_cyl_r < head_r, rd_cyl_r};
  always_comb begin
    if (mode_r == drs_pkg::MODE_SSTF) better = !found_r || key <= bkey_r;
    else better = !found_r || key < bkey_r;
  end
  assign pick = (mode_r == drs_pkg::MODE_SSTF || mode_r == drs_pkg::MODE_CLOOK) ?
                best_r : slot_r[IW-1:0];

  always_comb begin
    count_add = count_r;
    if (ctrl.store && in_has && count_r < CW'(drs_pkg::MAX_BATCH)) begin
      count_add = count_r + CW'(1);
    end
  end

  assign close = ctrl.store && (in_end || count_add >= limit);
  assign count_nxt = close ? '0 : count_add;

  assign stat.count_zero = (n_r == '0);
  assign stat.limit_hit = (count_add >= limit);
  // scan_last waits for scan_r to reach n_r, so the registered read of the last entry is still compared
  assign stat.scan_last = (scan_r >= n_r);
  assign stat.emit_last = (slot_r + CW'(1) >= n_r);
  assign stat.out_busy = out_v_r && !out_tready;

  always_comb begin
    served_nxt = served_r;
    if (ctrl.start_batch) served_nxt = '0;
    if (ctrl.pick) served_nxt[pick] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctrl.store && in_has && count_r < CW'(drs_pkg::MAX_BATCH)) begin
      cyl_mem[count_r[IW-1:0]] <= in_cyl;
      tag_mem[count_r[IW-1:0]] <= in_tag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      n_r <= '0;
      head_r <= '0;
      served_r <= '0;
      scan_r <= '0;
      slot_r <= '0;
      found_r <= 1'b0;
      out_v_r <= 1'b0;
      mode_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      served_r <= served_nxt;
      if (close) begin
        n_r <= count_add;
        mode_r <= mode;
      end
      if (ctrl.start_batch) slot_r <= '0;
      if (ctrl.scan_clear) begin
        scan_r <= '0;
        found_r <= 1'b0;
      end
      rd_v_r <= ctrl.scan_step && (scan_r < n_r);
      if (ctrl.scan_step) begin
        scan_r <= scan_r + CW'(1);
        rd_idx_r <= si;
        rd_cyl_r <= cyl_mem[si];
      end
      if (rd_v_r && !served_r[rd_idx_r] && better) begin
        found_r <= 1'b1;
        best_r <= rd_idx_r;
        bkey_r <= key;
      end
      if (ctrl.pick) begin
        sel_r <= pick;
        hi_r <= (slot_r + CW'(1) >= n_r);
      end
      if (ctrl.emit_done) begin
        out_v_r <= 1'b1;
        ocyl_r <= cyl_mem[sel_r];
        otag_r <= tag_mem[sel_r];
        olast_r <= hi_r;
        slot_r <= slot_r + CW'(1);
        if (mode_r == drs_pkg::MODE_SSTF || (mode_r == drs_pkg::MODE_CLOOK && hi_r)) begin
          head_r <= cyl_mem[sel_r];
        end
      end else if (out_v_r && out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_cyl = ocyl_r;
  assign out_tag = otag_r;
  assign out_last = olast_r;

endmodule

// ===== test/tb_disk_request_scheduler_unit.sv =====
module tb_disk_request_scheduler_unit;

  localparam logic [1:0] MODE_FCFS = 2'd0;
  localparam logic [1:0] MODE_ALT  = 2'd3;
  localparam int LIMIT_CYCLES = 2000000;

  typedef struct packed {
    logic [drs_pkg::TAG_W-1:0] tag;
    logic [drs_pkg::CYL_W-1:0] cyl;
    logic                      last;
  } served_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;   // cylinder[15:0], request_tag[7:0]
  logic        in_tuser;   // has_request
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // served_tag[7:0], served_cylinder[15:0]
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  disk_request_scheduler_unit uut (.*);

  // scheduler shadow state
  logic [1:0]                sh_mode;
  logic [5:0]                sh_bsize;
  logic [drs_pkg::CYL_W-1:0] sh_head;
  logic [drs_pkg::CYL_W-1:0] sh_cyl [drs_pkg::MAX_BATCH];
  logic [drs_pkg::TAG_W-1:0] sh_tag [drs_pkg::MAX_BATCH];
  int                        sh_count;

  served_t service_queue[$];
  int  errors = 0;
  int  served_seen = 0;
  int  requests_sent = 0;
  int  batches_closed = 0;
  bit  idle_on = 1;
  int  hold_cycles = 0;
  longint cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic int unsigned seek_dist(logic [drs_pkg::CYL_W-1:0] a,
                                            logic [drs_pkg::CYL_W-1:0] b);
    return (a >= b) ? 32'(a - b) : 32'(b - a);
  endfunction

  function automatic void schedule_batch();
    int n;
    int order [drs_pkg::MAX_BATCH];
    int sorted [drs_pkg::MAX_BATCH];
    bit done [drs_pkg::MAX_BATCH];
    int best, bestd, d, j, v, start;
    served_t r;
    n = sh_count;
    if (n == 0) return;
    batches_closed++;
    if (sh_mode == drs_pkg::MODE_SSTF) begin
      for (int i = 0; i < n; i++) done[i] = 0;
      for (int i = 0; i < n; i++) begin
        best = -1;
        bestd = 0;
        for (int k = 0; k < n; k++) begin
          if (done[k]) continue;
          d = seek_dist(sh_cyl[k], sh_head);
          if (best < 0 || d <= bestd) begin
            best = k;
            bestd = d;
          end
        end
        done[best] = 1;
        sh_head = sh_cyl[best];
        order[i] = best;
      end
    end else if (sh_mode == drs_pkg::MODE_CLOOK) begin
      for (int i = 0; i < n; i++) begin
        v = i;
        j = i;
        while (j > 0 && sh_cyl[sorted[j-1]] > sh_cyl[v]) begin
          sorted[j] = sorted[j-1];
          j--;
        end
        sorted[j] = v;
      end
      start = 0;
      while (start < n && sh_cyl[sorted[start]] < sh_head) start++;
      if (start >= n) start = 0;
      for (int i = 0; i < n; i++) order[i] = sorted[(start + i) % n];
      sh_head = sh_cyl[order[n-1]];
    end else begin
      for (int i = 0; i < n; i++) order[i] = i;
    end
    for (int i = 0; i < n; i++) begin
      r.tag = sh_tag[order[i]];
      r.cyl = sh_cyl[order[i]];
      r.last = (i == n - 1);
      service_queue.push_back(r);
    end
    sh_count = 0;
  endfunction

  function automatic void accept_request(logic has, logic [drs_pkg::CYL_W-1:0] cyl,
                                         logic [drs_pkg::TAG_W-1:0] tag, logic close);
    int lim;
    if (has && sh_count < drs_pkg::MAX_BATCH) begin
      sh_cyl[sh_count] = cyl;
      sh_tag[sh_count] = tag;
      sh_count++;
    end
    lim = (sh_bsize < 1) ? 1 : (sh_bsize > drs_pkg::MAX_BATCH) ? drs_pkg::MAX_BATCH : sh_bsize;
    if (close || sh_count >= lim) schedule_batch();
  endfunction

  always @(posedge clk) begin
    served_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      served_seen++;
      if (service_queue.size() == 0) begin
        $error("unexpected result tag=%0d cyl=%0d", out_tdata[7:0], out_tdata[23:8]);
        errors++;
      end else begin
        exp_r = service_queue.pop_front();
        if (out_tdata[7:0] !== exp_r.tag) begin
          $error("served_tag expected %0d got %0d", exp_r.tag, out_tdata[7:0]);
          errors++;
        end
        if (out_tdata[23:8] !== exp_r.cyl) begin
          $error("served_cylinder expected %0d got %0d", exp_r.cyl, out_tdata[23:8]);
          errors++;
        end
        if (out_tlast !== exp_r.last) begin
          $error("last_in_batch expected %0d got %0d", exp_r.last, out_tlast);
          errors++;
        end
      end
    end
  end

  // result-side stall generator; hold_cycles forces one long hold-off
  initial begin
    int g;
    out_tready = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready = 0;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready = 0;
        g = $urandom_range(1, 11);
        repeat (g - 1) @(negedge clk);
      end else begin
        out_tready = 1;
      end
    end
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] data);
    @(negedge clk);
    cfg_psel = 1;
    cfg_penable = 0;
    cfg_pwrite = 1;
    cfg_paddr = addr;
    cfg_pwdata = data;
    @(negedge clk);
    cfg_penable = 1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
  endtask

  task automatic send_item(logic has, logic [drs_pkg::CYL_W-1:0] cyl,
                           logic [drs_pkg::TAG_W-1:0] tag, logic close);
    int g;
    @(negedge clk);
    in_tvalid = 1;
    in_tdata = {tag, cyl};
    in_tuser = has;
    in_tlast = close;
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    accept_request(has, cyl, tag, close);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_tvalid = 0;
      g = $urandom_range(1, 11);
      repeat (g - 1) @(negedge clk);
    end
  endtask

  task automatic send_req(logic [drs_pkg::CYL_W-1:0] cyl, logic [drs_pkg::TAG_W-1:0] tag,
                          logic close);
    send_item(1'b1, cyl, tag, close);
  endtask

  task automatic send_flush(logic close);
    send_item(1'b0, 16'($urandom), 8'($urandom), close);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid = 0;
    in_tlast = 0;
    while (service_queue.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // close any open batch, wait for idle, then set both registers
  task automatic set_mode(logic [1:0] mode, logic [5:0] bsize);
    if (sh_count != 0) send_req(16'd7, 8'd7, 1'b1);
    drain();
    cfg_write({drs_pkg::ADDR_MODE, 2'b00}, {30'd0, mode});
    sh_mode = mode;
    cfg_write({drs_pkg::ADDR_BATCH, 2'b00}, {26'd0, bsize});
    sh_bsize = bsize;
  endtask

  task automatic test_fcfs_extremes();
    set_mode(MODE_FCFS, 6'd4);
    send_req(16'hFFFF, 8'hFF, 0);
    send_req(16'h0000, 8'h00, 0);
    send_req(16'h5555, 8'hAA, 0);
    send_req(16'hAAAA, 8'h55, 0);
    send_req(16'h1234, 8'h01, 1);
  endtask

  task automatic test_flush_markers();
    set_mode(MODE_FCFS, 6'd4);
    send_flush(0);
    send_flush(1);
    send_req(16'd300, 8'd30, 0);
    send_flush(0);
    send_req(16'd200, 8'd31, 0);
    send_flush(1);
    send_flush(1);
    set_mode(drs_pkg::MODE_CLOOK, 6'd32);
    send_req(16'd40, 8'd32, 0);
    send_req(16'd60, 8'd33, 0);
    drain();
    cfg_write({drs_pkg::ADDR_BATCH, 2'b00}, 32'd2);
    sh_bsize = 6'd2;
    send_flush(0);
  endtask

  task automatic test_sstf_ties();
    set_mode(drs_pkg::MODE_SSTF, 6'd32);
    send_req(16'd100, 8'd1, 0);
    send_req(16'd100, 8'd2, 0);
    send_req(16'd80, 8'd3, 0);
    send_req(16'd120, 8'd4, 0);
    send_req(16'd0, 8'd5, 1);
  endtask

  task automatic test_clook_wrap();
    set_mode(drs_pkg::MODE_CLOOK, 6'd6);
    send_req(16'd50, 8'd10, 0);
    send_req(16'd10, 8'd11, 0);
    send_req(16'd50, 8'd12, 0);
    send_req(16'd9000, 8'd13, 0);
    send_req(16'd20, 8'd14, 0);
    send_req(16'd70, 8'd15, 0);
    send_req(16'd5, 8'd16, 1);
  endtask

  task automatic test_mode_alias_and_sizes();
    set_mode(MODE_ALT, 6'd0);
    send_req(16'd3, 8'd20, 0);
    send_req(16'd4, 8'd21, 0);
    set_mode(drs_pkg::MODE_SSTF, 6'd63);
    for (int i = 0; i < 33; i++) send_req(16'($urandom), 8'($urandom), 0);
  endtask

  task automatic test_lowered_limit();
    set_mode(drs_pkg::MODE_CLOOK, 6'd32);
    for (int i = 0; i < 5; i++) send_req(16'($urandom), 8'($urandom), 0);
    drain();
    cfg_write({drs_pkg::ADDR_BATCH, 2'b00}, 32'd3);
    sh_bsize = 6'd3;
    send_req(16'($urandom), 8'($urandom), 0);
  endtask

  task automatic test_backpressure();
    set_mode(drs_pkg::MODE_SSTF, 6'd8);
    hold_cycles = 2000;
    for (int i = 0; i < 40; i++) send_req(16'($urandom), 8'($urandom), 0);
  endtask

  task automatic test_random(int n_items, bit quiet);
    int left;
    int k;
    logic [5:0] bs;
    left = n_items;
    idle_on = !quiet;
    while (left > 0) begin
      bs = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(1, 8));
      set_mode(2'($urandom_range(0, 3)), bs);
      k = $urandom_range(8, 30);
      for (int i = 0; i < k && left > 0; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_flush($urandom_range(0, 2) == 0);
        else if ($urandom_range(0, 3) == 0)
          send_req(16'($urandom_range(0, 40)), 8'($urandom), $urandom_range(0, 5) == 0);
        else
          send_req(16'($urandom), 8'($urandom), $urandom_range(0, 5) == 0);
        left--;
      end
    end
  endtask

  initial begin
    rst_n = 0;
    in_tvalid = 0;
    in_tdata = '0;
    in_tuser = 0;
    in_tlast = 0;
    cfg_psel = 0;
    cfg_penable = 0;
    cfg_pwrite = 0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    sh_mode = MODE_FCFS;
    sh_bsize = 6'd32;
    sh_head = '0;
    sh_count = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    test_fcfs_extremes();
    test_flush_markers();
    test_sstf_ties();
    test_clook_wrap();
    test_mode_alias_and_sizes();
    test_lowered_limit();
    test_backpressure();
    test_random(270, 0);
    test_random(60, 1);
    if (sh_count != 0) send_req(16'd1, 8'd1, 1'b1);
    drain();

    $display("sent %0d requests in %0d batches, checked %0d served slots",
             requests_sent, batches_closed, served_seen);
    $display("modes FCFS/SSTF/C-LOOK/alias, batch sizes 0..63, flush markers, long hold-off");
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== disk_request_scheduler_unit.f =====
sv/drs_pkg.sv
sv/drs_ctrl.sv
sv/drs_dp.sv
sv/disk_request_scheduler_unit.sv
test/tb_disk_request_scheduler_unit.sv
